// ----- rtl/rte_pkg.sv -----
// Shared types and codes of the route table engine.
// Used by the core, the RAM users and the port checker; no dependencies.
`timescale 1ns / 1ps
package rte_pkg;

  localparam logic [3:0] OP_INSERT      = 4'd0;
  localparam logic [3:0] OP_UPDATE      = 4'd1;
  localparam logic [3:0] OP_FIND        = 4'd2;
  localparam logic [3:0] OP_FIND_ACTIVE = 4'd3;
  localparam logic [3:0] OP_INVALIDATE  = 4'd4;
  localparam logic [3:0] OP_DELETE      = 4'd5;
  localparam logic [3:0] OP_PREC_ADD    = 4'd6;
  localparam logic [3:0] OP_PREC_REMOVE = 4'd7;
  localparam logic [3:0] OP_PREC_PURGE  = 4'd8;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
  localparam logic [2:0] ST_EXISTS      = 3'd2;
  localparam logic [2:0] ST_NO_SLOT     = 3'd3;
  localparam logic [2:0] ST_INVALID     = 3'd4;

  localparam logic [1:0] TA_NONE        = 2'd0;
  localparam logic [1:0] TA_EXPIRE      = 2'd1;
  localparam logic [1:0] TA_DELETE      = 2'd2;
  localparam logic [1:0] TA_CANCEL      = 2'd3;

  localparam logic [1:0] KA_NONE        = 2'd0;
  localparam logic [1:0] KA_ADD         = 2'd1;
  localparam logic [1:0] KA_CHANGE      = 2'd2;
  localparam logic [1:0] KA_DELETE      = 2'd3;

  localparam logic       CFG_INF_HOPS   = 1'b0;
  localparam logic       CFG_DEL_PERIOD = 1'b1;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] nhop;
    logic [7:0]  hops;
    logic [7:0]  last_hops;
    logic [31:0] seqno;
    logic [15:0] flags;
    logic [7:0]  ifindex;
    logic        tmr_del;
  } ent_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] addr;
  } prec_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] nhop;
    logic [7:0]  hops;
    logic [7:0]  last_hops;
    logic [31:0] seqno;
    logic [15:0] flags;
    logic [7:0]  ifindex;
    logic [1:0]  timer_action;
    logic [31:0] timer_msec;
    logic [1:0]  kernel_action;
  } res_t;

endpackage

// ----- rtl/rte_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/route_table_engine_core.sv -----
// Top level of the route table engine: sequencer around the entry RAM and
// the precursor RAM. Depends on rte_pkg and rte_ram.
`timescale 1ns / 1ps
//
// Channel   Handshake               Payload
// input     start, busy             in_op .. in_neighbor_addr
// result    out_valid (strobe)      out_status .. out_kernel_action
// config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// An unknown op returns its word in the cycle after acceptance.
// Table ops run an accept step, the bucket remainder (four address bits a cycle),
// a read and a compare per way probed, and an execute step; the probe stops at a hit or after the last way.
// A precursor purge sweeps every entry of the precursor RAM, reading each row and writing back those of valid entries.
// Reset clears the entry valid bits at once; no clearing pass is needed.
// Results cannot be stalled; busy holds off new words until one is finished.
module route_table_engine_core
  import rte_pkg::*;
#(
  parameter int BUCKETS              = 64,
  parameter int WAYS                 = 4,
  parameter int PRECURSORS_PER_ENTRY = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_op,
  input  logic [31:0] in_dest_addr,
  input  logic [31:0] in_next_hop_in,
  input  logic [7:0]  in_hops_in,
  input  logic [31:0] in_seqno_in,
  input  logic [31:0] in_lifetime_in,
  input  logic [15:0] in_flags_in,
  input  logic [7:0]  in_ifindex_in,
  input  logic [31:0] in_neighbor_addr,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_next_hop_out,
  output logic [7:0]  out_hops_out,
  output logic [7:0]  out_last_hops_out,
  output logic [31:0] out_seqno_out,
  output logic [15:0] out_flags_out,
  output logic [7:0]  out_ifindex_out,
  output logic [1:0]  out_timer_action,
  output logic [31:0] out_timer_msec,
  output logic [1:0]  out_kernel_action,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NENT   = BUCKETS * WAYS;
  localparam int EAW    = NENT > 1 ? $clog2(NENT) : 1;
  localparam int RW     = $clog2(BUCKETS) + 1;
  localparam int WW     = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int PW     = PRECURSORS_PER_ENTRY > 1 ? $clog2(PRECURSORS_PER_ENTRY) : 1;
  localparam int ROW_W  = PRECURSORS_PER_ENTRY * $bits(prec_t);

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_PRB_RD, S_PRB_CMP, S_EXEC, S_PRG_RD, S_PRG_WR
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  op_r;
  logic [31:0] dest_r, nh_r, seq_r, life_r, nb_r;
  logic [7:0]  hops_r, ifx_r;
  logic [15:0] flags_r;
  logic [31:0] sh_r, sh_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [WW-1:0] way_r, way_nxt;
  logic        hit_r, hit_nxt, free_r, free_nxt;
  logic [EAW-1:0] idx_r, idx_nxt, free_idx_r, free_idx_nxt, k_r, k_nxt;
  logic [NENT-1:0] vld_r;
  logic        vld_we, vld_val;
  logic [EAW-1:0] vld_idx;
  logic [7:0]  inf_r;
  logic [31:0] del_r;
  res_t        res_r, res_nxt;
  logic        outv_r, outv_nxt;

  logic [EAW-1:0] probe_idx, tgt;
  logic        ent_we, ent_re, prec_we, prec_re;
  logic [EAW-1:0] ent_raddr, prec_raddr, prec_waddr;
  ent_t        ent_rd, ent_new;
  logic [$bits(ent_t)-1:0] ent_rdata;
  logic [ROW_W-1:0] prec_rdata;
  prec_t [PRECURSORS_PER_ENTRY-1:0] prow_rd, prow_new, prow_rm;
  logic        present, fs_found;
  logic [PW-1:0] fs;

  function automatic logic [RW-1:0] mod_step(logic [RW-1:0] r, logic [3:0] bits);
    logic [RW-1:0] t;
    t = r;
    for (int i = 3; i >= 0; i--) begin
      t = (t << 1) | RW'(bits[i]);
      if (t >= RW'(BUCKETS)) begin
        t = t - RW'(BUCKETS);
      end
    end
    return t;
  endfunction

  rte_ram #(.WIDTH($bits(ent_t)), .DEPTH(NENT)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(tgt), .wdata(ent_new),
    .re(ent_re), .raddr(ent_raddr), .rdata(ent_rdata)
  );

  rte_ram #(.WIDTH(ROW_W), .DEPTH(NENT)) u_prec_ram (
    .clk(clk), .we(prec_we), .waddr(prec_waddr), .wdata(prow_new),
    .re(prec_re), .raddr(prec_raddr), .rdata(prec_rdata)
  );

  assign ent_rd    = ent_rdata;
  assign prow_rd   = prec_rdata;
  assign probe_idx = EAW'(rem_r * WAYS + way_r);
  assign tgt       = hit_r ? idx_r : free_idx_r;

  // Precursor slot scan: match removal, presence and the first free slot.
  always_comb begin
    present  = 1'b0;
    fs_found = 1'b0;
    fs       = '0;
    for (int p = 0; p < PRECURSORS_PER_ENTRY; p++) begin
      prow_rm[p] = prow_rd[p];
      if (prow_rd[p].vld) begin
        if (prow_rd[p].addr == nb_r) begin
          present        = 1'b1;
          prow_rm[p].vld = 1'b0;
        end
      end else if (!fs_found) begin
        fs_found = 1'b1;
        fs       = PW'(p);
      end
    end
  end

  always_comb begin
    logic show;
    state_nxt    = state_r;
    sh_nxt       = sh_r;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    way_nxt      = way_r;
    hit_nxt      = hit_r;
    free_nxt     = free_r;
    idx_nxt      = idx_r;
    free_idx_nxt = free_idx_r;
    k_nxt        = k_r;
    res_nxt      = '0;
    outv_nxt     = 1'b0;
    vld_we       = 1'b0;
    vld_val      = 1'b0;
    vld_idx      = tgt;
    ent_we       = 1'b0;
    ent_re       = 1'b0;
    ent_raddr    = probe_idx;
    prec_we      = 1'b0;
    prec_re      = 1'b0;
    prec_raddr   = probe_idx;
    prec_waddr   = tgt;
    ent_new      = ent_rd;
    prow_new     = prow_rd;
    show         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          sh_nxt   = in_dest_addr;
          cnt_nxt  = '0;
          rem_nxt  = '0;
          way_nxt  = '0;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          k_nxt    = '0;
          if (in_op > OP_PREC_PURGE) begin
            outv_nxt = 1'b1;
          end else if (in_op == OP_PREC_PURGE) begin
            state_nxt = S_PRG_RD;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        rem_nxt = mod_step(rem_r, sh_r[31:28]);
        sh_nxt  = sh_r << 4;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = S_PRB_RD;
        end
      end
      S_PRB_RD: begin
        ent_re    = 1'b1;
        state_nxt = S_PRB_CMP;
      end
      S_PRB_CMP: begin
        if (vld_r[probe_idx] && ent_rd.dest == dest_r) begin
          hit_nxt   = 1'b1;
          idx_nxt   = probe_idx;
          prec_re   = 1'b1;
          state_nxt = S_EXEC;
        end else begin
          if (!vld_r[probe_idx] && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = probe_idx;
          end
          if (way_r == WW'(WAYS - 1)) begin
            state_nxt = S_EXEC;
          end else begin
            way_nxt   = way_r + WW'(1);
            state_nxt = S_PRB_RD;
          end
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        outv_nxt  = 1'b1;
        if (op_r == OP_INSERT) begin
          if (hit_r) begin
            res_nxt.status = ST_EXISTS;
            show           = 1'b1;
          end else if (!free_r) begin
            res_nxt.status = ST_NO_SLOT;
          end else begin
            ent_new = '{dest: dest_r, nhop: nh_r, hops: hops_r, last_hops: 8'd0,
                        seqno: seq_r, flags: flags_r, ifindex: ifx_r,
                        tmr_del: hops_r == inf_r};
            prow_new = '0;
            ent_we   = 1'b1;
            prec_we  = 1'b1;
            vld_we   = 1'b1;
            vld_val  = 1'b1;
            show     = 1'b1;
            if (hops_r == inf_r) begin
              res_nxt.timer_action = TA_DELETE;
              res_nxt.timer_msec   = del_r;
            end else begin
              res_nxt.timer_action  = TA_EXPIRE;
              res_nxt.timer_msec    = life_r;
              res_nxt.kernel_action = KA_ADD;
            end
          end
        end else if (!hit_r) begin
          res_nxt.status = ST_NOT_FOUND;
        end else begin
          show = 1'b1;
          case (op_r)
            OP_UPDATE: begin
              if (ent_rd.hops == inf_r && hops_r != inf_r) begin
                ent_new.tmr_del       = 1'b0;
                res_nxt.kernel_action = KA_ADD;
              end else if (ent_rd.nhop != 32'd0 && ent_rd.nhop != nh_r) begin
                prow_new              = '0;
                prec_we               = 1'b1;
                res_nxt.kernel_action = KA_CHANGE;
              end
              ent_new.seqno     = seq_r;
              ent_new.flags     = flags_r;
              ent_new.nhop      = nh_r;
              ent_new.last_hops = ent_rd.hops;
              ent_new.hops      = hops_r;
              ent_we            = 1'b1;
              if (life_r != 32'd0) begin
                res_nxt.timer_action = ent_new.tmr_del ? TA_DELETE : TA_EXPIRE;
                res_nxt.timer_msec   = life_r;
              end
            end
            OP_FIND: begin
            end
            OP_FIND_ACTIVE: begin
              if (ent_rd.hops == inf_r) begin
                res_nxt.status = ST_NOT_FOUND;
                show           = 1'b0;
              end
            end
            OP_INVALIDATE: begin
              res_nxt.timer_action = TA_CANCEL;
              if (ent_rd.hops == inf_r) begin
                res_nxt.status = ST_INVALID;
              end else begin
                ent_new.last_hops     = ent_rd.hops;
                ent_new.hops          = inf_r;
                ent_new.seqno         = ent_rd.seqno + 32'd1;
                ent_new.flags         = '0;
                ent_new.tmr_del       = 1'b1;
                ent_we                = 1'b1;
                res_nxt.kernel_action = KA_DELETE;
                res_nxt.timer_action  = TA_DELETE;
                res_nxt.timer_msec    = del_r;
              end
            end
            OP_DELETE: begin
              // The precursor row is cleared again by the insert that reuses the slot.
              vld_we               = 1'b1;
              vld_val              = 1'b0;
              res_nxt.timer_action = TA_CANCEL;
              if (ent_rd.hops != inf_r) begin
                res_nxt.kernel_action = KA_DELETE;
              end
            end
            OP_PREC_ADD: begin
              if (!present) begin
                if (!fs_found) begin
                  res_nxt.status = ST_NO_SLOT;
                  show           = 1'b0;
                end else begin
                  prow_new[fs].vld  = 1'b1;
                  prow_new[fs].addr = nb_r;
                  prec_we           = 1'b1;
                end
              end
            end
            default: begin
              prow_new = prow_rm;
              prec_we  = 1'b1;
            end
          endcase
        end
        if (show) begin
          res_nxt.nhop      = ent_new.nhop;
          res_nxt.hops      = ent_new.hops;
          res_nxt.last_hops = ent_new.last_hops;
          res_nxt.seqno     = ent_new.seqno;
          res_nxt.flags     = ent_new.flags;
          res_nxt.ifindex   = ent_new.ifindex;
        end
      end
      S_PRG_RD: begin
        prec_re    = 1'b1;
        prec_raddr = k_r;
        state_nxt  = S_PRG_WR;
      end
      S_PRG_WR: begin
        prec_waddr = k_r;
        prow_new   = prow_rm;
        prec_we    = vld_r[k_r];
        if (k_r == EAW'(NENT - 1)) begin
          outv_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + EAW'(1);
          state_nxt = S_PRG_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      outv_r  <= 1'b0;
      vld_r   <= '0;
      inf_r   <= 8'd255;
      del_r   <= 32'd10000;
    end else begin
      state_r <= state_nxt;
      outv_r  <= outv_nxt;
      if (vld_we) begin
        vld_r[vld_idx] <= vld_val;
      end
      if (cfg_valid && cfg_index == CFG_INF_HOPS) begin
        inf_r <= cfg_data[7:0];
      end
      if (cfg_valid && cfg_index == CFG_DEL_PERIOD) begin
        del_r <= cfg_data;
      end
    end
    res_r      <= res_nxt;
    sh_r       <= sh_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    way_r      <= way_nxt;
    hit_r      <= hit_nxt;
    free_r     <= free_nxt;
    idx_r      <= idx_nxt;
    free_idx_r <= free_idx_nxt;
    k_r        <= k_nxt;
    if (state_r == S_IDLE && start) begin
      op_r    <= in_op;
      dest_r  <= in_dest_addr;
      nh_r    <= in_next_hop_in;
      hops_r  <= in_hops_in;
      seq_r   <= in_seqno_in;
      life_r  <= in_lifetime_in;
      flags_r <= in_flags_in;
      ifx_r   <= in_ifindex_in;
      nb_r    <= in_neighbor_addr;
    end
  end

  assign busy              = state_r != S_IDLE;
  assign cfg_ready         = 1'b1;
  assign out_valid         = outv_r;
  assign out_status        = res_r.status;
  assign out_next_hop_out  = res_r.nhop;
  assign out_hops_out      = res_r.hops;
  assign out_last_hops_out = res_r.last_hops;
  assign out_seqno_out     = res_r.seqno;
  assign out_flags_out     = res_r.flags;
  assign out_ifindex_out   = res_r.ifindex;
  assign out_timer_action  = res_r.timer_action;
  assign out_timer_msec    = res_r.timer_msec;
  assign out_kernel_action = res_r.kernel_action;

endmodule

// ----- rtl/rte_checker.sv -----
// Port-level checks of the route table engine, bound to the top level.
// Depends on rte_pkg and route_table_engine_core.
`timescale 1ns / 1ps
module rte_checker
  import rte_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [3:0]  in_op,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [1:0]  out_timer_action,
  input logic [31:0] out_timer_msec,
  input logic [1:0]  out_kernel_action
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not quiet after reset");

  a_table_op_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op <= OP_PREC_PURGE |=> busy && !out_valid)
    else $error("table word did not start work");

  a_fail_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOT_FOUND || out_status == ST_EXISTS ||
                  out_status == ST_NO_SLOT)
    |-> out_timer_action == TA_NONE && out_kernel_action == KA_NONE)
    else $error("failed word carries an action");

  a_msec_only_arm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_timer_action == TA_NONE || out_timer_action == TA_CANCEL)
    |-> out_timer_msec == 32'd0)
    else $error("timer time without an arming action");

endmodule

bind route_table_engine_core rte_checker u_rte_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_op(in_op),
  .out_valid(out_valid), .out_status(out_status),
  .out_timer_action(out_timer_action), .out_timer_msec(out_timer_msec),
  .out_kernel_action(out_kernel_action)
);
